// ----- design/prsd_pkg.sv -----
// Shared types and codes for the palette run-length sprite decoder.
// No dependencies; imported by the top level, the parser and the colour pipeline.
package prsd_pkg;

    localparam logic [1:0] REQ_PAL_WRITE   = 2'd0;
    localparam logic [1:0] REQ_FRAME_START = 2'd1;
    localparam logic [1:0] REQ_FRAME_DATA  = 2'd2;

    localparam logic [1:0] MODE_RGB  = 2'd0;
    localparam logic [1:0] MODE_RGBA = 2'd1;
    localparam logic [1:0] MODE_BGRA = 2'd2;

    localparam int PAL_W     = 24;
    localparam int PAL_DEPTH = 256;

    // One pixel request leaving the parser
    typedef struct packed {
        logic        valid;
        logic        err;
        logic [19:0] pos;
        logic [7:0]  alpha;
        logic        pal_ok;
    } pix_req_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] trans_red;
        logic [7:0] trans_green;
        logic [7:0] trans_blue;
        logic [7:0] threshold;
    } cfg_t;

    // floor(x / 255), exact for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ----- design/palette_rle_sprite_decoder_unit.sv -----
// Top level of the palette run-length sprite decoder: configuration
// registers, parser, palette RAM and colour pipeline.
// Depends on prsd_pkg, prsd_ram, prsd_parser and prsd_colour.
//
// Usage
//   Input channel (in_valid / in_stall): one item per cycle while in_stall is low.
//   req_type selects a palette write (pal_index, pal_red, pal_green, pal_blue),
//   a frame start (frame_size) or one byte of the run-length stream (data_byte).
//   Output channel (out_valid / out_stall): one decoded pixel per item that
//   carries a palette index inside a coloured run; other items give nothing.
//   Configuration: APB-style, registers at byte addresses 0, 4, 8, 12, 16
//   (colour_mode, trans_red, trans_green, trans_blue, alpha_threshold);
//   write only while no item is in flight.
//   Pipeline: an accepted index byte passes through s1, s2 and the output register.
//   Throughput: one item per cycle while out_stall does not freeze the pipeline,
//   bound by the single read port of the palette RAM, read on acceptance.
//   Stall: out_stall freezes the whole three-stage pipeline, and in_stall
//   rises with it while a finished pixel waits in the output register.
//   Reset: parser idle, no frame (every pixel overruns until a frame start),
//   colour_mode RGBA, others zero; palette entries read as zero until
//   written, tracked by one valid bit per entry.
module palette_rle_sprite_decoder_unit #(
    parameter int MAX_PIXELS = 1048576
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  pal_index,
    input  logic [7:0]  pal_red,
    input  logic [7:0]  pal_green,
    input  logic [7:0]  pal_blue,
    input  logic [20:0] frame_size,
    input  logic [7:0]  data_byte,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [19:0] pixel_index,
    output logic [7:0]  chan_first,
    output logic [7:0]  chan_second,
    output logic [7:0]  chan_third,
    output logic [7:0]  alpha_out,
    output logic        overflow_error,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import prsd_pkg::*;

    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_TRANS_R   = 3'd1;
    localparam logic [2:0] CFG_TRANS_G   = 3'd2;
    localparam logic [2:0] CFG_TRANS_B   = 3'd3;
    localparam logic [2:0] CFG_THRESHOLD = 3'd4;

    logic [1:0] colour_mode_reg;
    logic [7:0] trans_red_reg, trans_green_reg, trans_blue_reg, threshold_reg;
    logic       cfg_write;
    cfg_t       cfg;

    logic        advance;
    logic        accept;
    pix_req_t    pix;
    logic        ram_we;
    logic [7:0]  ram_waddr;
    logic [23:0] ram_wdata;
    logic [7:0]  ram_raddr;
    logic [23:0] ram_rdata;

    // ---- configuration port ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_mode_reg <= MODE_RGBA;
            trans_red_reg   <= '0;
            trans_green_reg <= '0;
            trans_blue_reg  <= '0;
            threshold_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                CFG_MODE:      colour_mode_reg <= pwdata[1:0];
                CFG_TRANS_R:   trans_red_reg   <= pwdata[7:0];
                CFG_TRANS_G:   trans_green_reg <= pwdata[7:0];
                CFG_TRANS_B:   trans_blue_reg  <= pwdata[7:0];
                CFG_THRESHOLD: threshold_reg   <= pwdata[7:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            CFG_MODE:      prdata = {30'b0, colour_mode_reg};
            CFG_TRANS_R:   prdata = {24'b0, trans_red_reg};
            CFG_TRANS_G:   prdata = {24'b0, trans_green_reg};
            CFG_TRANS_B:   prdata = {24'b0, trans_blue_reg};
            CFG_THRESHOLD: prdata = {24'b0, threshold_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.mode        = colour_mode_reg;
    assign cfg.trans_red   = trans_red_reg;
    assign cfg.trans_green = trans_green_reg;
    assign cfg.trans_blue  = trans_blue_reg;
    assign cfg.threshold   = threshold_reg;

    // ---- datapath ----
    // hold the input whenever the pipeline is frozen by the receiver
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    prsd_parser #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .req_type   (req_type),
        .pal_index  (pal_index),
        .pal_red    (pal_red),
        .pal_green  (pal_green),
        .pal_blue   (pal_blue),
        .frame_size (frame_size),
        .data_byte  (data_byte),
        .pix        (pix),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr)
    );

    // a write and a later read of the same entry never share a clock edge,
    // so the read always sees the written colour
    prsd_ram #(
        .WIDTH (PAL_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    prsd_colour u_colour (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .pix            (pix),
        .pal_rdata      (ram_rdata),
        .cfg            (cfg),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .pixel_index    (pixel_index),
        .chan_first     (chan_first),
        .chan_second    (chan_second),
        .chan_third     (chan_third),
        .alpha_out      (alpha_out),
        .overflow_error (overflow_error)
    );

`ifndef NO_ASSERTIONS
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting pixel");

    a_overflow_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow_error) |-> (pixel_index == 20'd0 && alpha_out == 8'd0
            && chan_first == 8'd0 && chan_second == 8'd0 && chan_third == 8'd0))
        else $error("overrun pixel carries non-zero fields");

    a_rgb_no_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && colour_mode_reg == MODE_RGB) |-> (alpha_out == 8'd0))
        else $error("alpha output set in blended mode");
`endif

endmodule

// ----- design/prsd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module prsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/prsd_parser.sv -----
// Stream parser: frame state, run tracking, overrun latch, palette write and
// read issue, palette valid bits. Depends on prsd_pkg.
module prsd_parser #(
    parameter int MAX_PIXELS = 1048576
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            req_type,
    input  logic [7:0]            pal_index,
    input  logic [7:0]            pal_red,
    input  logic [7:0]            pal_green,
    input  logic [7:0]            pal_blue,
    input  logic [20:0]           frame_size,
    input  logic [7:0]            data_byte,
    output prsd_pkg::pix_req_t    pix,
    output logic                  ram_we,
    output logic [7:0]            ram_waddr,
    output logic [23:0]           ram_wdata,
    output logic [7:0]            ram_raddr
);

    import prsd_pkg::*;

    typedef enum logic [1:0] {
        PH_COUNT,
        PH_ALPHA,
        PH_INDEX
    } phase_t;

    localparam int CMP_W = (21 > $clog2(MAX_PIXELS + 1)) ? 21 : $clog2(MAX_PIXELS + 1);
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PIXELS);
    localparam logic [20:0] POS_MAX = 21'h1FFFFF;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  run_left_reg,  run_left_next;
    logic [7:0]  run_alpha_reg, run_alpha_next;
    logic [20:0] pos_reg,    pos_next;
    logic [20:0] limit_reg,  limit_next;
    logic        err_reg,    err_next;
    logic [PAL_DEPTH-1:0] pal_valid_reg;

    logic [CMP_W-1:0] fs_wide;
    logic [21:0]      skip_end;
    logic             pix_err;
    logic             data_item;

    assign fs_wide   = CMP_W'(frame_size);
    assign skip_end  = {1'b0, pos_reg} + {14'b0, run_left_reg};
    assign pix_err   = err_reg || (pos_reg >= limit_reg);
    assign data_item = accept && (req_type == REQ_FRAME_DATA);

    assign ram_we    = accept && (req_type == REQ_PAL_WRITE);
    assign ram_waddr = pal_index;
    assign ram_wdata = {pal_red, pal_green, pal_blue};
    assign ram_raddr = data_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        run_left_next  = run_left_reg;
        run_alpha_next = run_alpha_reg;
        pos_next       = pos_reg;
        limit_next     = limit_reg;
        err_next       = err_reg;
        pix            = '0;

        if (accept && (req_type == REQ_FRAME_START))
        begin
            limit_next     = (fs_wide > MAX_CMP) ? MAX_CMP[20:0] : frame_size;
            pos_next       = '0;
            phase_next     = PH_COUNT;
            run_left_next  = '0;
            run_alpha_next = '0;
            err_next       = 1'b0;
        end
        else if (data_item)
        begin
            case (phase_reg)
                PH_ALPHA:
                begin
                    run_alpha_next = data_byte;
                    if (data_byte == 8'd0)
                    begin
                        // transparent run: jump position, no pixels
                        if (run_left_reg != 8'd0)
                        begin
                            if (skip_end > {1'b0, limit_reg})
                            begin
                                err_next = 1'b1;
                            end
                            pos_next = skip_end[21] ? POS_MAX : skip_end[20:0];
                        end
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        phase_next = (run_left_reg == 8'd0) ? PH_COUNT : PH_INDEX;
                    end
                end
                PH_INDEX:
                begin
                    pix.valid  = 1'b1;
                    pix.err    = pix_err;
                    pix.pos    = pos_reg[19:0];
                    pix.alpha  = run_alpha_reg;
                    pix.pal_ok = pal_valid_reg[data_byte];
                    err_next   = pix_err;
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 21'd1;
                    end
                    if (run_left_reg != 8'd0)
                    begin
                        run_left_next = run_left_reg - 8'd1;
                    end
                    if (run_left_reg <= 8'd1)
                    begin
                        phase_next = PH_COUNT;
                    end
                end
                default:
                begin
                    run_left_next = data_byte;
                    phase_next    = PH_ALPHA;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            run_left_reg  <= '0;
            run_alpha_reg <= '0;
            pos_reg       <= '0;
            limit_reg     <= '0;
            err_reg       <= 1'b0;
            pal_valid_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_left_reg  <= run_left_next;
            run_alpha_reg <= run_alpha_next;
            pos_reg       <= pos_next;
            limit_reg     <= limit_next;
            err_reg       <= err_next;
            if (ram_we)
            begin
                pal_valid_reg[pal_index] <= 1'b1;
            end
        end
    end

endmodule

// ----- design/prsd_colour.sv -----
// Colour pipeline: palette lookup result, blend products, divide by 255,
// channel ordering and the output register. Depends on prsd_pkg.
module prsd_colour (
    input  logic               clk,
    input  logic               rst_n,
    output logic               advance,
    input  prsd_pkg::pix_req_t pix,
    input  logic [23:0]        pal_rdata,
    input  prsd_pkg::cfg_t     cfg,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [19:0]        pixel_index,
    output logic [7:0]         chan_first,
    output logic [7:0]         chan_second,
    output logic [7:0]         chan_third,
    output logic [7:0]         alpha_out,
    output logic               overflow_error
);

    import prsd_pkg::*;

    pix_req_t    s1_reg;
    pix_req_t    s2_reg;
    logic [23:0] s2_rgb_reg;
    logic [15:0] s2_sum_r_reg, s2_sum_g_reg, s2_sum_b_reg;

    logic [23:0] entry;
    logic [7:0]  inv_a;
    logic [15:0] sum_r, sum_g, sum_b;
    logic [7:0]  c1, c2, c3, ao;

    logic        out_valid_reg;
    logic [19:0] pixel_index_reg;
    logic [7:0]  chan_first_reg, chan_second_reg, chan_third_reg, alpha_out_reg;
    logic        overflow_reg;

    assign advance = !out_valid_reg || !out_stall;

    // entries never written read as zero
    assign entry = s1_reg.pal_ok ? pal_rdata : 24'd0;
    assign inv_a = 8'hFF - s1_reg.alpha;
    assign sum_r = ({8'b0, entry[23:16]} * {8'b0, s1_reg.alpha})
                 + ({8'b0, cfg.trans_red} * {8'b0, inv_a});
    assign sum_g = ({8'b0, entry[15:8]} * {8'b0, s1_reg.alpha})
                 + ({8'b0, cfg.trans_green} * {8'b0, inv_a});
    assign sum_b = ({8'b0, entry[7:0]} * {8'b0, s1_reg.alpha})
                 + ({8'b0, cfg.trans_blue} * {8'b0, inv_a});

    always_comb
    begin
        case (cfg.mode)
            MODE_RGB:
            begin
                ao = 8'd0;
                if (s2_reg.alpha < cfg.threshold)
                begin
                    c1 = cfg.trans_red;
                    c2 = cfg.trans_green;
                    c3 = cfg.trans_blue;
                end
                else
                begin
                    c1 = div255(s2_sum_r_reg);
                    c2 = div255(s2_sum_g_reg);
                    c3 = div255(s2_sum_b_reg);
                end
            end
            MODE_BGRA:
            begin
                c1 = s2_rgb_reg[7:0];
                c2 = s2_rgb_reg[15:8];
                c3 = s2_rgb_reg[23:16];
                ao = s2_reg.alpha;
            end
            default:
            begin
                c1 = s2_rgb_reg[23:16];
                c2 = s2_rgb_reg[15:8];
                c3 = s2_rgb_reg[7:0];
                ao = s2_reg.alpha;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_reg        <= pix;
            s2_reg        <= s1_reg;
            out_valid_reg <= s2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_rgb_reg   <= entry;
            s2_sum_r_reg <= sum_r;
            s2_sum_g_reg <= sum_g;
            s2_sum_b_reg <= sum_b;
            if (s2_reg.err)
            begin
                pixel_index_reg <= '0;
                chan_first_reg  <= '0;
                chan_second_reg <= '0;
                chan_third_reg  <= '0;
                alpha_out_reg   <= '0;
                overflow_reg    <= 1'b1;
            end
            else
            begin
                pixel_index_reg <= s2_reg.pos;
                chan_first_reg  <= c1;
                chan_second_reg <= c2;
                chan_third_reg  <= c3;
                alpha_out_reg   <= ao;
                overflow_reg    <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign pixel_index    = pixel_index_reg;
    assign chan_first     = chan_first_reg;
    assign chan_second    = chan_second_reg;
    assign chan_third     = chan_third_reg;
    assign alpha_out      = alpha_out_reg;
    assign overflow_error = overflow_reg;

endmodule
